### src/sacl_pkg.sv
// shared types and constants for the set-associative cache lookup core
// no dependencies; imported by every module of the block but the line store
package sacl_pkg;

  localparam int unsigned CNT_W         = 16;
  localparam int unsigned TOTAL_W       = 32;
  localparam int unsigned TIME_W        = 16;
  localparam int unsigned SET_BITS_W    = 3;
  localparam int unsigned OFFSET_BITS_W = 5;
  localparam int unsigned ADDR_BITS_W   = 7;
  localparam int unsigned WAYS_W        = 4;
  localparam int unsigned CFG_DW        = 32;
  localparam int unsigned CFG_AW        = 5;

  typedef enum logic [2:0] {
    REG_SET_BITS     = 3'd0,
    REG_OFFSET_BITS  = 3'd1,
    REG_ADDRESS_BITS = 3'd2,
    REG_WAYS         = 3'd3,
    REG_POLICY       = 3'd4,
    REG_HIT_TIME     = 3'd5,
    REG_MISS_PENALTY = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    POL_LRU = 1'b0,
    POL_LFU = 1'b1
  } policy_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic start;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    logic found;
    logic hit;
  } scan_stat_t;

endpackage

### src/sacl_addr_split.sv
// splits an address into set index and tag from the configured bit counts
// depends on sacl_pkg
module sacl_addr_split import sacl_pkg::*; #(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned ADDR_WIDTH   = 64,
  localparam int unsigned SET_W       = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  logic [ADDR_WIDTH-1:0]    addr_i,
  input  logic [SET_BITS_W-1:0]    set_bits_i,
  input  logic [OFFSET_BITS_W-1:0] offset_bits_i,
  input  logic [ADDR_BITS_W-1:0]   address_bits_i,
  output logic [SET_W-1:0]         set_idx_o,
  output logic [ADDR_WIDTH-1:0]    tag_o
);

  logic [SET_BITS_W-1:0]          sb;
  logic [ADDR_WIDTH+SET_W-1:0]    addr_off;
  logic [5:0]                     tag_shamt;
  logic [ADDR_WIDTH-1:0]          addr_hi;
  logic signed [8:0]              tag_w;

  always_comb begin
    if ({1'b0, set_bits_i} > 4'(MAX_SET_BITS)) begin
      sb = SET_BITS_W'(MAX_SET_BITS);
    end else begin
      sb = set_bits_i;
    end
    addr_off  = {{SET_W{1'b0}}, addr_i} >> offset_bits_i;
    tag_shamt = 6'(sb) + 6'(offset_bits_i);
    addr_hi   = addr_i >> tag_shamt;
    tag_w     = $signed({2'b00, address_bits_i}) - $signed({6'b0, sb})
              - $signed({4'b0, offset_bits_i});
  end

  always_comb begin
    for (int i = 0; i < SET_W; i++) begin
      set_idx_o[i] = addr_off[i] & (4'(i) < {1'b0, sb});
    end
  end

  // tag keeps only the bits below the tag width, none when it is not positive
  always_comb begin
    for (int i = 0; i < ADDR_WIDTH; i++) begin
      tag_o[i] = addr_hi[i] & (tag_w > $signed(9'(i)));
    end
  end

endmodule

### src/sacl_line_ram.sv
// line store: one row per set, all ways of the set side by side
// per-row written flags stand in for the reset contents; depends on nothing
module sacl_line_ram #(
  parameter int unsigned ROW_AW = 6,
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [ROW_AW-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  output logic              rd_fresh_o,
  input  logic              wr_en_i,
  input  logic [ROW_AW-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i
);

  localparam int unsigned DEPTH = 2 ** ROW_AW;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic [DEPTH-1:0]  written_q;
  logic              rd_fresh_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q  <= '0;
      rd_fresh_q <= 1'b1;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_fresh_q <= ~written_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o  = rd_data_q;
  assign rd_fresh_o = rd_fresh_q;

endmodule

### src/sacl_way_scan.sv
// shared way compare unit: one way per step, tracks the hit or free way
// and both replacement victims; depends on sacl_pkg
module sacl_way_scan import sacl_pkg::*; #(
  parameter int unsigned ADDR_WIDTH = 64,
  parameter int unsigned WAY_W      = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  scan_ctl_t             ctl_i,
  input  logic [WAY_W-1:0]      way_i,
  input  logic                  valid_i,
  input  logic [ADDR_WIDTH-1:0] tag_i,
  input  logic [WAY_W-1:0]      rank_i,
  input  logic [CNT_W-1:0]      cnt_i,
  input  logic [ADDR_WIDTH-1:0] key_i,
  output scan_stat_t            stat_o,
  output logic [WAY_W-1:0]      found_way_o,
  output logic [WAY_W-1:0]      lru_way_o,
  output logic [WAY_W-1:0]      lfu_way_o
);

  logic             found_q;
  logic             hit_q;
  logic [WAY_W-1:0] fway_q;
  logic [WAY_W-1:0] lru_q;
  logic [WAY_W-1:0] lfu_q;
  logic [CNT_W-1:0] least_q;
  logic             tag_eq;

  assign tag_eq = (tag_i == key_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      hit_q   <= 1'b0;
    end else if (ctl_i.start) begin
      found_q <= 1'b0;
      hit_q   <= 1'b0;
    end else if (ctl_i.step && !found_q) begin
      if (!valid_i) begin
        found_q <= 1'b1;
      end else if (tag_eq) begin
        found_q <= 1'b1;
        hit_q   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      lru_q <= '0;
    end else if (ctl_i.step) begin
      if (!found_q && (!valid_i || tag_eq)) begin
        fway_q <= way_i;
      end
      // last way with rank zero wins
      if (rank_i == '0) begin
        lru_q <= way_i;
      end
      // first way with the smallest count wins
      if (way_i == '0 || cnt_i < least_q) begin
        least_q <= cnt_i;
        lfu_q   <= way_i;
      end
    end
  end

  assign stat_o.found = found_q;
  assign stat_o.hit   = hit_q;
  assign found_way_o  = fway_q;
  assign lru_way_o    = lru_q;
  assign lfu_way_o    = lfu_q;

endmodule

### src/set_assoc_cache_lru_lfu_core.sv
// Set-associative cache lookup core with LRU or LFU replacement.
// Input channel: one address per beat (in_valid_i / in_stall_o). Output
// channel: one beat per address with hit flag and saturating hit, miss and
// cycle totals (out_valid_o / out_stall_i). Configuration: APB registers at
// byte addresses 4*i, written by the user only while idle (not enforced).
// Sequence: after an address is accepted the block reads the set's row,
// compares the tag against one way per cycle over the ways in use
// (1..MAX_WAYS) and writes the row back with the result, which loads the
// output beat. The serial tag compare of the way scan sets the item rate.
// The input stalls while an item is in work; an item may be accepted while
// the previous result still waits, and a stalled output holds its beat while
// the next item waits at write-back.
// Reset: configuration returns to its defaults, the totals clear, and every
// set reads as empty with ranks equal to way numbers through per-set written
// flags, so no clearing pass is needed and an item is taken right away.
// depends on sacl_pkg, sacl_addr_split, sacl_line_ram, sacl_way_scan
module set_assoc_cache_lru_lfu_core import sacl_pkg::*; #(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned MAX_WAYS     = 8,
  parameter int unsigned ADDR_WIDTH   = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ADDR_WIDTH-1:0] address_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o,
  output logic [TOTAL_W-1:0]    hit_total_o,
  output logic [TOTAL_W-1:0]    miss_total_o,
  output logic [TOTAL_W-1:0]    cycle_total_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_AW-1:0]     paddr,
  input  logic [CFG_DW-1:0]     pwdata,
  output logic [CFG_DW-1:0]     prdata,
  output logic                  pready
);

  localparam int unsigned SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned NW     = WAY_W + 1;
  localparam int unsigned LINE_W = 1 + ADDR_WIDTH + WAY_W + CNT_W;
  localparam int unsigned ROW_W  = MAX_WAYS * LINE_W;
  localparam int unsigned RANK_LO = CNT_W;
  localparam int unsigned TAG_LO  = CNT_W + WAY_W;

  // configuration
  logic [SET_BITS_W-1:0]    set_bits_q;
  logic [OFFSET_BITS_W-1:0] offset_bits_q;
  logic [ADDR_BITS_W-1:0]   address_bits_q;
  logic [WAYS_W-1:0]        ways_q;
  policy_e                  policy_q;
  logic [TIME_W-1:0]        hit_time_q;
  logic [TIME_W-1:0]        miss_penalty_q;
  logic                     cfg_wr;
  cfg_reg_e                 cfg_sel;

  // sequencer
  state_e                   state_q, state_d;
  logic [SET_W-1:0]         set_q;
  logic [ADDR_WIDTH-1:0]    key_q;
  logic [WAY_W-1:0]         way_q;
  logic [NW-1:0]            n_w;
  logic                     scan_last;
  logic                     in_acc;
  logic                     rd_en;
  logic                     load;
  scan_ctl_t                scan_ctl;

  // address split
  logic [SET_W-1:0]         split_set;
  logic [ADDR_WIDTH-1:0]    split_tag;

  // row data
  logic [ROW_W-1:0]         rd_row;
  logic                     rd_fresh;
  logic [ROW_W-1:0]         wr_row;
  logic                     ln_valid [MAX_WAYS];
  logic [ADDR_WIDTH-1:0]    ln_tag   [MAX_WAYS];
  logic [WAY_W-1:0]         ln_rank  [MAX_WAYS];
  logic [CNT_W-1:0]         ln_cnt   [MAX_WAYS];

  // scan results
  scan_stat_t               scan_stat;
  logic [WAY_W-1:0]         found_way;
  logic [WAY_W-1:0]         lru_way;
  logic [WAY_W-1:0]         lfu_way;

  // update
  logic                     hit_w;
  logic                     direct;
  logic [WAY_W-1:0]         tgt_way;
  logic [WAY_W-1:0]         mru_way;
  logic                     mru_en;
  logic                     fill_en;
  logic                     cnt_clr;
  logic                     cnt_inc;
  logic [WAY_W-1:0]         mru_old;
  logic [WAY_W-1:0]         rank_top;

  // totals
  logic [TOTAL_W-1:0]       hit_cnt_q, hit_cnt_d;
  logic [TOTAL_W-1:0]       miss_cnt_q, miss_cnt_d;
  logic [TOTAL_W-1:0]       cyc_cnt_q, cyc_cnt_d;
  logic [TIME_W:0]          cyc_add;
  logic [TOTAL_W:0]         cyc_sum;
  logic                     hit_q;
  logic                     out_valid_q;

  // ---------------------------------------------------------------- config

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q     <= SET_BITS_W'(4);
      offset_bits_q  <= OFFSET_BITS_W'(4);
      address_bits_q <= ADDR_BITS_W'(64);
      ways_q         <= WAYS_W'(2);
      policy_q       <= POL_LRU;
      hit_time_q     <= TIME_W'(1);
      miss_penalty_q <= TIME_W'(100);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_SET_BITS:     set_bits_q     <= pwdata[SET_BITS_W-1:0];
        REG_OFFSET_BITS:  offset_bits_q  <= pwdata[OFFSET_BITS_W-1:0];
        REG_ADDRESS_BITS: address_bits_q <= pwdata[ADDR_BITS_W-1:0];
        REG_WAYS:         ways_q         <= pwdata[WAYS_W-1:0];
        REG_POLICY:       policy_q       <= policy_e'(pwdata[0]);
        REG_HIT_TIME:     hit_time_q     <= pwdata[TIME_W-1:0];
        REG_MISS_PENALTY: miss_penalty_q <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_SET_BITS:     prdata = CFG_DW'(set_bits_q);
      REG_OFFSET_BITS:  prdata = CFG_DW'(offset_bits_q);
      REG_ADDRESS_BITS: prdata = CFG_DW'(address_bits_q);
      REG_WAYS:         prdata = CFG_DW'(ways_q);
      REG_POLICY:       prdata = CFG_DW'(policy_q);
      REG_HIT_TIME:     prdata = CFG_DW'(hit_time_q);
      REG_MISS_PENALTY: prdata = CFG_DW'(miss_penalty_q);
      default:          prdata = '0;
    endcase
  end

  // ways in use, clamped to 1..MAX_WAYS
  always_comb begin
    if (ways_q == '0) begin
      n_w = NW'(1);
    end else if ({1'b0, ways_q} > 5'(MAX_WAYS)) begin
      n_w = NW'(MAX_WAYS);
    end else begin
      n_w = NW'(ways_q);
    end
  end

  // ------------------------------------------------------------- sequencer

  assign scan_last = (({1'b0, way_q} + NW'(1)) == n_w);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_READ;
      ST_READ:   state_d = ST_SCAN;
      ST_SCAN:   if (scan_last) state_d = ST_UPDATE;
      ST_UPDATE: if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o     = 1'b1;
    in_acc         = 1'b0;
    rd_en          = 1'b0;
    load           = 1'b0;
    scan_ctl.start = 1'b0;
    scan_ctl.step  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        in_acc     = in_valid_i;
      end
      ST_READ: begin
        rd_en          = 1'b1;
        scan_ctl.start = 1'b1;
      end
      ST_SCAN: begin
        scan_ctl.step = 1'b1;
      end
      ST_UPDATE: begin
        load = ~out_valid_q | ~out_stall_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      way_q   <= '0;
    end else begin
      state_q <= state_d;
      if (rd_en) begin
        way_q <= '0;
      end else if (scan_ctl.step) begin
        way_q <= way_q + WAY_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      set_q <= split_set;
      key_q <= split_tag;
    end
  end

  sacl_addr_split #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_split (
    .addr_i         (address_i),
    .set_bits_i     (set_bits_q),
    .offset_bits_i  (offset_bits_q),
    .address_bits_i (address_bits_q),
    .set_idx_o      (split_set),
    .tag_o          (split_tag)
  );

  // -------------------------------------------------------------- line store

  sacl_line_ram #(
    .ROW_AW (SET_W),
    .DATA_W (ROW_W)
  ) u_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (set_q),
    .rd_data_o  (rd_row),
    .rd_fresh_o (rd_fresh),
    .wr_en_i    (load),
    .wr_addr_i  (set_q),
    .wr_data_i  (wr_row)
  );

  // a set never written reads as empty with ranks equal to way numbers
  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (rd_fresh) begin
        ln_valid[j] = 1'b0;
        ln_tag[j]   = '0;
        ln_rank[j]  = WAY_W'(j);
        ln_cnt[j]   = '0;
      end else begin
        ln_valid[j] = rd_row[j*LINE_W + LINE_W - 1];
        ln_tag[j]   = rd_row[j*LINE_W + TAG_LO +: ADDR_WIDTH];
        ln_rank[j]  = rd_row[j*LINE_W + RANK_LO +: WAY_W];
        ln_cnt[j]   = rd_row[j*LINE_W +: CNT_W];
      end
    end
  end

  sacl_way_scan #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .WAY_W      (WAY_W)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scan_ctl),
    .way_i       (way_q),
    .valid_i     (ln_valid[way_q]),
    .tag_i       (ln_tag[way_q]),
    .rank_i      (ln_rank[way_q]),
    .cnt_i       (ln_cnt[way_q]),
    .key_i       (key_q),
    .stat_o      (scan_stat),
    .found_way_o (found_way),
    .lru_way_o   (lru_way),
    .lfu_way_o   (lfu_way)
  );

  // ------------------------------------------------------------ write-back

  always_comb begin
    hit_w    = scan_stat.found & scan_stat.hit;
    direct   = (n_w == NW'(1));
    if (scan_stat.found) begin
      tgt_way = found_way;
    end else if (policy_q == POL_LFU) begin
      tgt_way = lfu_way;
    end else begin
      tgt_way = lru_way;
    end
    mru_way  = scan_stat.found ? found_way : lru_way;
    mru_en   = ~direct & (scan_stat.found | (policy_q == POL_LRU));
    fill_en  = ~hit_w;
    cnt_clr  = ~direct & ~hit_w & (scan_stat.found | (policy_q == POL_LFU));
    cnt_inc  = ~direct & hit_w;
    mru_old  = ln_rank[mru_way];
    rank_top = WAY_W'(n_w - NW'(1));
  end

  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      logic             is_tgt;
      logic [CNT_W-1:0] cnt_nx;
      logic [WAY_W-1:0] rank_nx;
      is_tgt  = (tgt_way == WAY_W'(j));
      cnt_nx  = ln_cnt[j];
      rank_nx = ln_rank[j];
      if (is_tgt && cnt_clr) begin
        cnt_nx = '0;
      end else if (is_tgt && cnt_inc && (ln_cnt[j] != '1)) begin
        cnt_nx = ln_cnt[j] + CNT_W'(1);
      end
      if (mru_en && (NW'(j) < n_w)) begin
        if (mru_way == WAY_W'(j)) begin
          rank_nx = rank_top;
        end else if (ln_rank[j] > mru_old) begin
          rank_nx = ln_rank[j] - WAY_W'(1);
        end
      end
      wr_row[j*LINE_W + LINE_W - 1]         = ln_valid[j] | (is_tgt & fill_en);
      wr_row[j*LINE_W + TAG_LO +: ADDR_WIDTH] = (is_tgt && fill_en) ? key_q : ln_tag[j];
      wr_row[j*LINE_W + RANK_LO +: WAY_W]   = rank_nx;
      wr_row[j*LINE_W +: CNT_W]             = cnt_nx;
    end
  end

  // ---------------------------------------------------------------- totals

  always_comb begin
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    if (hit_w) begin
      if (hit_cnt_q != '1) hit_cnt_d = hit_cnt_q + TOTAL_W'(1);
      cyc_add = {1'b0, hit_time_q};
    end else begin
      if (miss_cnt_q != '1) miss_cnt_d = miss_cnt_q + TOTAL_W'(1);
      cyc_add = {1'b0, hit_time_q} + {1'b0, miss_penalty_q};
    end
    cyc_sum   = {1'b0, cyc_cnt_q} + (TOTAL_W + 1)'(cyc_add);
    cyc_cnt_d = cyc_sum[TOTAL_W] ? '1 : cyc_sum[TOTAL_W-1:0];
  end

  // the totals double as the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      cyc_cnt_q   <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      cyc_cnt_q   <= cyc_cnt_d;
      hit_q       <= hit_w;
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign hit_total_o   = hit_cnt_q;
  assign miss_total_o  = miss_cnt_q;
  assign cycle_total_o = cyc_cnt_q;

endmodule

### src/sacl_checker.sv
// port-level checks for the cache lookup core, bound to the top level
// depends on sacl_pkg and set_assoc_cache_lru_lfu_core
module sacl_checker import sacl_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               hit_o,
  input logic [TOTAL_W-1:0] hit_total_o,
  input logic [TOTAL_W-1:0] miss_total_o,
  input logic [TOTAL_W-1:0] cycle_total_o
);

  // an accepted beat keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after an accepted beat");

  a_totals_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (hit_total_o >= $past(hit_total_o)) &&
             (miss_total_o >= $past(miss_total_o)) &&
             (cycle_total_o >= $past(cycle_total_o)))
    else $error("a running total went down");

  // a hit total step comes with a valid hit beat and no miss step
  a_hit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_total_o != $past(hit_total_o)) |->
      (out_valid_o && hit_o && (miss_total_o == $past(miss_total_o))))
    else $error("hit total moved without a hit beat");

  a_miss_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (miss_total_o != $past(miss_total_o)) |->
      (out_valid_o && !hit_o && (hit_total_o == $past(hit_total_o))))
    else $error("miss total moved without a miss beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(hit_o) && $stable(hit_total_o) &&
       $stable(miss_total_o) && $stable(cycle_total_o)))
    else $error("stalled output beat changed");

endmodule

bind set_assoc_cache_lru_lfu_core sacl_checker u_sacl_checker (.*);

### tb/sv/tb_set_assoc_cache_lru_lfu_core.sv
// testbench for set_assoc_cache_lru_lfu_core: directed and random address traffic
// checked beat by beat against an in-bench cache model; needs sacl_pkg and the core rtl
`timescale 1ns / 100ps

module tb_set_assoc_cache_lru_lfu_core;
  import sacl_pkg::*;

  localparam int unsigned MAX_SET_BITS  = 6;
  localparam int unsigned MAX_WAYS      = 8;
  localparam int unsigned ADDR_WIDTH    = 64;
  localparam int unsigned NUM_LINES     = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int unsigned NUM_CFG_REGS  = int'(REG_MISS_PENALTY) + 1;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned STUCK_LIMIT   = 2000;
  localparam int unsigned PRINT_LIMIT   = 50;
  localparam int unsigned RAND_PHASES   = 7;
  localparam int unsigned PHASE_ITEMS   = 64;
  localparam int unsigned BURST_ITEMS   = 40;
  localparam logic [CFG_AW-1:0] SPARE_REG_ADDR = 5'd28;
  localparam logic [CFG_DW-1:0] FIELD_MASK [NUM_CFG_REGS] =
    '{32'h7, 32'h1F, 32'h7F, 32'hF, 32'h1, 32'hFFFF, 32'hFFFF};
  localparam logic [CFG_DW-1:0] RESET_VALUE [NUM_CFG_REGS] =
    '{32'd4, 32'd4, 32'd64, 32'd2, 32'd0, 32'd1, 32'd100};

  typedef struct packed {
    logic               hit;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
    logic [TOTAL_W-1:0] cycle_total;
  } access_result_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [ADDR_WIDTH-1:0] address_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  hit_o;
  logic [TOTAL_W-1:0]    hit_total_o;
  logic [TOTAL_W-1:0]    miss_total_o;
  logic [TOTAL_W-1:0]    cycle_total_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [CFG_AW-1:0]     paddr       = '0;
  logic [CFG_DW-1:0]     pwdata      = '0;
  logic [CFG_DW-1:0]     prdata;
  logic                  pready;

  // cache model state
  bit   [CFG_DW-1:0]  cfg_regs  [NUM_CFG_REGS];
  bit                 line_vld  [NUM_LINES];
  bit   [63:0]        line_tag  [NUM_LINES];
  bit   [2:0]         line_rank [NUM_LINES];
  bit   [15:0]        line_uses [NUM_LINES];
  bit   [TOTAL_W-1:0] hits_q, misses_q, cycles_q;

  access_result_t pending_results [$];
  int unsigned    error_count  = 0;
  int unsigned    stuck_cycles = 0;
  bit             calm         = 1'b0;

  set_assoc_cache_lru_lfu_core #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .MAX_WAYS    (MAX_WAYS),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .address_i    (address_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hit_o        (hit_o),
    .hit_total_o  (hit_total_o),
    .miss_total_o (miss_total_o),
    .cycle_total_o(cycle_total_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic void reset_cache_model();
    for (int i = 0; i < NUM_CFG_REGS; i++) cfg_regs[i] = RESET_VALUE[i];
    for (int i = 0; i < NUM_LINES; i++) begin
      line_vld[i]  = 1'b0;
      line_tag[i]  = '0;
      line_rank[i] = 3'(i % MAX_WAYS);
      line_uses[i] = '0;
    end
    hits_q   = '0;
    misses_q = '0;
    cycles_q = '0;
  endfunction

  function automatic bit [TOTAL_W-1:0] sat_add(input bit [TOTAL_W-1:0] a, input bit [63:0] b);
    bit [63:0] sum;
    sum = 64'(a) + b;
    return (sum > 64'hFFFF_FFFF) ? '1 : sum[TOTAL_W-1:0];
  endfunction

  function automatic void promote_mru(input int unsigned base, input int unsigned w,
                                      input int unsigned n);
    bit [2:0] old_rank;
    old_rank = line_rank[base + w];
    line_rank[base + w] = 3'(n - 1);
    for (int unsigned j = 0; j < n; j++)
      if (j != w && line_rank[base + j] > old_rank) line_rank[base + j]--;
  endfunction

  // one access against the model: updates lines and totals, returns the expected beat
  function automatic access_result_t lookup_access(input logic [63:0] addr);
    int unsigned    sbits, obits, n, base, victim;
    int             tag_w;
    bit   [63:0]    tag;
    bit   [15:0]    least;
    bit             hit, done;
    access_result_t res;
    sbits = (cfg_regs[REG_SET_BITS] > MAX_SET_BITS) ? MAX_SET_BITS : cfg_regs[REG_SET_BITS];
    obits = cfg_regs[REG_OFFSET_BITS];
    n = (cfg_regs[REG_WAYS] == 0) ? 1 :
        ((cfg_regs[REG_WAYS] > MAX_WAYS) ? MAX_WAYS : cfg_regs[REG_WAYS]);
    tag_w = int'(cfg_regs[REG_ADDRESS_BITS]) - int'(sbits) - int'(obits);
    base  = int'((addr >> obits) & ((64'd1 << sbits) - 64'd1)) * MAX_WAYS;
    if (tag_w <= 0) tag = '0;
    else if (tag_w >= 64) tag = addr >> (sbits + obits);
    else tag = (addr >> (sbits + obits)) & ((64'd1 << tag_w) - 64'd1);
    hit  = 1'b0;
    done = 1'b0;
    if (n == 1) begin
      // direct mapped: ranks and use counts stay as they are
      if (line_vld[base] && line_tag[base] == tag) begin
        hit = 1'b1;
      end else begin
        line_vld[base] = 1'b1;
        line_tag[base] = tag;
      end
    end else begin
      for (int unsigned w = 0; w < n && !done; w++) begin
        if (!line_vld[base + w]) begin
          line_vld[base + w]  = 1'b1;
          line_tag[base + w]  = tag;
          line_uses[base + w] = '0;
          promote_mru(base, w, n);
          done = 1'b1;
        end else if (line_tag[base + w] == tag) begin
          if (line_uses[base + w] != 16'hFFFF) line_uses[base + w]++;
          promote_mru(base, w, n);
          hit  = 1'b1;
          done = 1'b1;
        end
      end
      if (!done) begin
        victim = 0;
        if (policy_e'(cfg_regs[REG_POLICY][0]) == POL_LRU) begin
          // last way holding rank zero wins, use count survives
          for (int unsigned w = 0; w < n; w++)
            if (line_rank[base + w] == 0) victim = w;
          promote_mru(base, victim, n);
          line_tag[base + victim] = tag;
        end else begin
          least = line_uses[base];
          for (int unsigned w = 0; w < n; w++) begin
            if (line_uses[base + w] < least) begin
              least  = line_uses[base + w];
              victim = w;
            end
          end
          line_tag[base + victim]  = tag;
          line_uses[base + victim] = '0;
        end
      end
    end
    if (hit) begin
      hits_q   = sat_add(hits_q, 64'd1);
      cycles_q = sat_add(cycles_q, 64'(cfg_regs[REG_HIT_TIME]));
    end else begin
      misses_q = sat_add(misses_q, 64'd1);
      cycles_q = sat_add(cycles_q, 64'(cfg_regs[REG_HIT_TIME]) + 64'(cfg_regs[REG_MISS_PENALTY]));
    end
    res.hit         = hit;
    res.hit_total   = hits_q;
    res.miss_total  = misses_q;
    res.cycle_total = cycles_q;
    return res;
  endfunction

  task automatic apb_transfer(input bit is_write, input logic [CFG_AW-1:0] addr,
                              input logic [CFG_DW-1:0] wdata,
                              output logic [CFG_DW-1:0] rdata);
    bit ready;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      ready = pready;
      rdata = prdata;
      @(posedge clk_i);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    // leave the bus idle before the next transfer
    @(posedge clk_i);
  endtask

  task automatic verify_reg(input cfg_reg_e r);
    logic [CFG_DW-1:0] rd;
    apb_transfer(1'b0, {r, 2'b00}, '0, rd);
    if (rd !== cfg_regs[r])
      report_mismatch($sformatf("reg %s read %h, want %h", r.name(), rd, cfg_regs[r]));
  endtask

  // junk above the field width must be dropped by the register
  task automatic write_reg(input cfg_reg_e r, input logic [CFG_DW-1:0] value);
    logic [CFG_DW-1:0] rd;
    apb_transfer(1'b1, {r, 2'b00}, (value & FIELD_MASK[r]) | ($urandom & ~FIELD_MASK[r]), rd);
    cfg_regs[r] = value & FIELD_MASK[r];
    verify_reg(r);
  endtask

  task automatic check_all_regs();
    for (int i = 0; i < NUM_CFG_REGS; i++) verify_reg(cfg_reg_e'(i));
  endtask

  task automatic send_access(input logic [63:0] addr);
    bit stalled;
    while (!calm && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    address_i  <= addr;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    pending_results.push_back(lookup_access(addr));
  endtask

  task automatic wait_results(input int unsigned settle);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  always @(posedge clk_i) out_stall_i <= !calm && ($urandom_range(99) < 24);

  always @(negedge clk_i) begin : check_results
    access_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending, hit=%b", hit_o));
      end else begin
        want = pending_results.pop_front();
        if (hit_o !== want.hit)
          report_mismatch($sformatf("hit %b, want %b", hit_o, want.hit));
        if (hit_total_o !== want.hit_total)
          report_mismatch($sformatf("hit_total %0d, want %0d", hit_total_o, want.hit_total));
        if (miss_total_o !== want.miss_total)
          report_mismatch($sformatf("miss_total %0d, want %0d", miss_total_o, want.miss_total));
        if (cycle_total_o !== want.cycle_total)
          report_mismatch($sformatf("cycle_total %0d, want %0d",
                                    cycle_total_o, want.cycle_total));
      end
    end
  end

  always @(negedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("[%0t] no progress for %0d cycles", $time, STUCK_LIMIT);
    $display("tb_set_assoc_cache_lru_lfu_core: done, errors");
    $finish;
  end

  task automatic test_reset_defaults();
    check_all_regs();
    send_access(64'h0);
    send_access(64'h0);
    send_access('1);
    send_access(64'hFFFF_FFFF_FFFF_FFF0);   // same block as all ones
    wait_results(SETTLE_CYCLES);
  endtask

  task automatic test_spare_register();
    logic [CFG_DW-1:0] rd;
    apb_transfer(1'b1, SPARE_REG_ADDR, {$urandom}, rd);
    check_all_regs();
  endtask

  task automatic test_direct_mapped();
    write_reg(REG_WAYS, 0);                // zero ways acts as one
    write_reg(REG_SET_BITS, 1);
    write_reg(REG_OFFSET_BITS, 2);
    send_access(64'h100);
    send_access(64'h100);
    send_access(64'h200);                  // same set, other tag
    send_access(64'h100);
    wait_results(SETTLE_CYCLES);
    write_reg(REG_WAYS, 1);
    send_access(64'h100);
    wait_results(SETTLE_CYCLES);
  endtask

  task automatic test_lru_eviction();
    write_reg(REG_WAYS, 4);
    write_reg(REG_POLICY, POL_LRU);
    write_reg(REG_SET_BITS, 7);            // clamps to the largest set count
    write_reg(REG_OFFSET_BITS, 0);
    for (int t = 1; t <= 4; t++) send_access((64'(t) << 6) | 64'd5);
    send_access((64'd1 << 6) | 64'd5);
    send_access((64'd5 << 6) | 64'd5);     // full set, evicts oldest
    send_access((64'd2 << 6) | 64'd5);
    wait_results(SETTLE_CYCLES);
  endtask

  task automatic test_lfu_eviction();
    write_reg(REG_WAYS, 3);
    write_reg(REG_POLICY, POL_LFU);
    for (int t = 1; t <= 3; t++) send_access((64'(t) << 6) | 64'd9);
    send_access((64'd1 << 6) | 64'd9);
    send_access((64'd3 << 6) | 64'd9);
    send_access((64'd4 << 6) | 64'd9);     // least used way goes
    wait_results(SETTLE_CYCLES);
  endtask

  task automatic test_tag_width();
    write_reg(REG_SET_BITS, 2);
    write_reg(REG_OFFSET_BITS, 4);
    write_reg(REG_ADDRESS_BITS, 4);        // negative tag width: tag is zero
    send_access(64'hAAAA_0000_0000_0030);
    send_access(64'h5555_0000_0000_0030);
    wait_results(SETTLE_CYCLES);
    write_reg(REG_ADDRESS_BITS, 127);      // tag keeps every bit above the index
    write_reg(REG_SET_BITS, 6);
    write_reg(REG_OFFSET_BITS, 31);
    send_access(64'h8000_0000_8000_0000);
    send_access(64'h8000_0000_8000_0000);
    wait_results(SETTLE_CYCLES);
  endtask

  // long run with no idling on either side, each miss at the largest cost
  task automatic test_max_cost_burst();
    calm = 1'b1;
    write_reg(REG_WAYS, 1);
    write_reg(REG_SET_BITS, 0);
    write_reg(REG_OFFSET_BITS, 0);
    write_reg(REG_ADDRESS_BITS, 64);
    write_reg(REG_HIT_TIME, 16'hFFFF);
    write_reg(REG_MISS_PENALTY, 16'hFFFF);
    // each address twice: a miss then a hit
    for (int i = 0; i < BURST_ITEMS; i++) send_access(64'(i / 2) + 64'd1);
    wait_results(SETTLE_CYCLES);
    calm = 1'b0;
  endtask

  function automatic logic [CFG_DW-1:0] pick_time_value();
    case ($urandom_range(3))
      0:       return 32'd0;
      1:       return 32'hFFFF;
      default: return $urandom_range(200);
    endcase
  endfunction

  task automatic test_random_traffic();
    int unsigned sbits, obits, n, pool_n, hold_at;
    logic [63:0] tag_pool [MAX_WAYS + 2];
    logic [63:0] hot_set  [3];
    logic [63:0] addr;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      write_reg(REG_SET_BITS, $urandom_range(7));
      write_reg(REG_OFFSET_BITS, ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(8));
      write_reg(REG_ADDRESS_BITS, ($urandom_range(2) == 0) ? $urandom_range(127) : 64);
      write_reg(REG_WAYS, $urandom_range(15));
      write_reg(REG_POLICY, phase % 2);
      write_reg(REG_HIT_TIME, pick_time_value());
      write_reg(REG_MISS_PENALTY, pick_time_value());
      sbits = (cfg_regs[REG_SET_BITS] > MAX_SET_BITS) ? MAX_SET_BITS : cfg_regs[REG_SET_BITS];
      obits = cfg_regs[REG_OFFSET_BITS];
      n = (cfg_regs[REG_WAYS] == 0) ? 1 :
          ((cfg_regs[REG_WAYS] > MAX_WAYS) ? MAX_WAYS : cfg_regs[REG_WAYS]);
      // a couple more tags than ways keeps hits and evictions both common
      pool_n = n + 2;
      foreach (tag_pool[i]) tag_pool[i] = {$urandom, $urandom};
      foreach (hot_set[i]) hot_set[i] = 64'($urandom_range((1 << sbits) - 1));
      // hold only once a beat is in flight
      hold_at = $urandom_range(PHASE_ITEMS - 1, 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == hold_at) wait_results(0);
        if ($urandom_range(99) < 85)
          addr = (tag_pool[$urandom_range(pool_n - 1)] << (sbits + obits))
               | (hot_set[$urandom_range(2)] << obits)
               | ({$urandom, $urandom} & ((64'd1 << obits) - 64'd1));
        else
          addr = {$urandom, $urandom};
        send_access(addr);
      end
      wait_results(SETTLE_CYCLES);
    end
  endtask

  initial begin
    reset_cache_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_spare_register();
    test_direct_mapped();
    test_lru_eviction();
    test_lfu_eviction();
    test_tag_width();
    test_random_traffic();
    test_max_cost_burst();
    wait_results(SETTLE_CYCLES);
    if (error_count == 0)
      $display("tb_set_assoc_cache_lru_lfu_core: done, clean");
    else
      $display("tb_set_assoc_cache_lru_lfu_core: done, errors");
    $finish;
  end

endmodule

### sim.f
src/sacl_pkg.sv
src/sacl_addr_split.sv
src/sacl_line_ram.sv
src/sacl_way_scan.sv
src/set_assoc_cache_lru_lfu_core.sv
src/sacl_checker.sv
tb/sv/tb_set_assoc_cache_lru_lfu_core.sv
